>>> rtl/vds_pkg.sv
// shared types, constants and functions of the vehicle drivetrain step block
package vds_pkg;

  // field and register widths
  localparam int PEDAL_W    = 16;
  localparam int WORD_W     = 32;
  localparam int GEAR_W     = 3;
  localparam int RATIO_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;
  localparam int DVD_W      = 64;
  localparam int DIV_CNT_W  = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENGINE_TORQUE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKING_FORCE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEHICLE_WEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO_TABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG_COEFF       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION_FORCE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UPSHIFT_RPM      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DOWNSHIFT_RPM    = 3'd7;

  // gears
  localparam logic [GEAR_W-1:0] GEAR_LOW = 3'd1;
  localparam logic [GEAR_W-1:0] GEAR_TOP = 3'd5;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // ratio of one gear out of the packed table, zero outside gears one to five
  function automatic logic [RATIO_W-1:0] gear_ratio(input logic [CFG_DATA_W-1:0] tab,
                                                    input logic [GEAR_W-1:0] g);
    logic [RATIO_W-1:0] r;
    unique case (g)
      3'd1:    r = tab[11:0];
      3'd2:    r = tab[23:12];
      3'd3:    r = tab[35:24];
      3'd4:    r = tab[47:36];
      3'd5:    r = tab[59:48];
      default: r = '0;
    endcase
    return r;
  endfunction

  // rpm product after the q4.8 shift, saturated to 32 bits
  function automatic logic [WORD_W-1:0] rpm_sat(input logic [35:0] x);
    logic [WORD_W-1:0] r;
    if (x[35:32] != 4'd0) begin
      r = '1;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/vds_if.sv
// valid/ready channel interfaces for the drivetrain step input and result beats
interface vds_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] throttle;
  logic [15:0] brake;
  logic [15:0] delta_time;

  modport source(output valid, output throttle, output brake, output delta_time,
                 input ready);
  modport sink(input valid, input throttle, input brake, input delta_time,
               output ready);
endinterface

interface vds_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] speed;
  logic [31:0] engine_rpm;
  logic [2:0]  current_gear;
  logic [15:0] applied_throttle;

  modport source(output valid, output speed, output engine_rpm, output current_gear,
                 output applied_throttle, input ready);
  modport sink(input valid, input speed, input engine_rpm, input current_gear,
               input applied_throttle, output ready);
endinterface

>>> rtl/vds_mul.sv
// shared 32 by 32 multiplier with registered product
module vds_mul import vds_pkg::*; (
  input  logic                clk,
  input  logic [WORD_W-1:0]   a,
  input  logic [WORD_W-1:0]   b,
  output logic [2*WORD_W-1:0] p
);

  logic [2*WORD_W-1:0] p_r;

  // product is registered and lands in the cycle after the operands
  always_ff @(posedge clk) begin
    p_r <= {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
  end

  assign p = p_r;

endmodule

>>> rtl/vds_div.sv
// bit-serial restoring divider, 64-bit dividend by 32-bit divisor
module vds_div import vds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [WORD_W-1:0]    divisor_r, divisor_nxt;
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [WORD_W-1:0]    rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [WORD_W:0]      rem_sh;
  logic [WORD_W:0]      rem_sub;
  logic                 ge;

  // one quotient bit per cycle, quotient shifts in behind the dividend
  always_comb begin
    rem_sh      = {rem_r, dvd_r[DVD_W-1]};
    rem_sub     = rem_sh - {1'b0, divisor_r};
    ge          = (rem_sh >= {1'b0, divisor_r});
    divisor_nxt = divisor_r;
    dvd_nxt     = dvd_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    if (req.start) begin
      // zero weight divides as one
      divisor_nxt = (req.divisor == '0) ? WORD_W'(1) : req.divisor;
      dvd_nxt     = req.dividend;
      rem_nxt     = '0;
      cnt_nxt     = '0;
      busy_nxt    = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    divisor_r <= divisor_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

>>> rtl/vehicle_drivetrain_step.sv
// vehicle drivetrain step: sequencer around a shared multiplier and serial divider
//
// Usage: write the eight configuration registers through cfg_we/cfg_index/cfg_data
// while the block is idle; each write lands on the rising edge with cfg_we high.
// Each beat on in_ch (throttle, brake, delta_time) advances the vehicle by one tick
// and yields exactly one beat on out_ch (speed, engine_rpm, current_gear,
// applied_throttle).
// The sequence takes extra steps when the gear shifts up or a downshift test
// runs. One tick at a time: in_ch.ready is high only in the idle state, so no
// new beat is taken until the last one's result is loaded. The 64 serial steps
// of the divider (net force times time step over weight) are the bulk of the
// work; the other steps issue up to twelve multiplies on the one shared 32x32 multiplier.
// The result sits in an output register; a new input beat is taken while it
// waits. If the receiver stalls, the next tick finishes its work and holds in its
// last step until the pending result has been taken.
// Reset: velocity and rpm clear, gear goes to one, configuration registers clear
// except the vehicle weight, which resets to 1.0. No output beat is pending after reset.
module vehicle_drivetrain_step import vds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  vds_in_if.sink                in_ch,
  vds_out_if.source             out_ch
);

  typedef enum logic [22:0] {
    S_IDLE = 23'h000001,
    S_APP  = 23'h000002,
    S_DRV1 = 23'h000004,
    S_DRV2 = 23'h000008,
    S_BRK  = 23'h000010,
    S_VSQ  = 23'h000020,
    S_DHI  = 23'h000040,
    S_DLO  = 23'h000080,
    S_DRAG = 23'h000100,
    S_RES  = 23'h000200,
    S_NET  = 23'h000400,
    S_MLO  = 23'h000800,
    S_MHI  = 23'h001000,
    S_MSUM = 23'h002000,
    S_DIV  = 23'h004000,
    S_VEL  = 23'h008000,
    S_R0   = 23'h010000,
    S_R1   = 23'h020000,
    S_R2   = 23'h040000,
    S_R3   = 23'h080000,
    S_DN   = 23'h100000,
    S_DN2  = 23'h200000,
    S_FIN  = 23'h400000
  } state_t;

  localparam logic [47:0] DRAG_MAX = 48'h8000_0000_0000;
  localparam logic [48:0] MAG_MAX  = 49'h0_8000_0000_0000;
  localparam logic [63:0] DV_MAX   = 64'h2_0000_0000;
  localparam logic [16:0] PEDAL_ONE = 17'h10000;
  localparam logic [WORD_W-1:0] RPM_ONE = 32'h0001_0000;

  // configuration registers
  logic [WORD_W-1:0]     torque_r, brkf_r, wgt_r, dragc_r, fric_r, upshift_r, downshift_r;
  logic [CFG_DATA_W-1:0] ratio_tab_r;

  // sequencer and work registers
  state_t              state_r, state_nxt;
  logic [PEDAL_W-1:0]  thr_r, thr_nxt, brk_r, brk_nxt, dt_r, dt_nxt, app_r, app_nxt;
  logic [35:0]         drive_r, drive_nxt;
  logic [48:0]         resist_r, resist_nxt;
  logic [15:0]         v2lo_r, v2lo_nxt;
  logic                dsat_r, dsat_nxt;
  logic [46:0]         dhi_r, dhi_nxt;
  logic [47:0]         drag_r, drag_nxt;
  logic                neg_r, neg_nxt;
  logic [47:0]         mag_r, mag_nxt;
  logic [47:0]         plo_r, plo_nxt;
  logic [WORD_W-1:0]   vn_r, vn_nxt, rpmw_r, rpmw_nxt;
  logic [WORD_W-1:0]   vel_r, vel_nxt, rpm_r, rpm_nxt;
  logic [GEAR_W-1:0]   gear_r, gear_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   o_speed_r, o_speed_nxt, o_rpm_r, o_rpm_nxt;
  logic [GEAR_W-1:0]   o_gear_r, o_gear_nxt;
  logic [PEDAL_W-1:0]  o_app_r, o_app_nxt;

  // shared units
  logic [WORD_W-1:0]   mul_a, mul_b;
  logic [2*WORD_W-1:0] mul_p;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // scratch
  logic [WORD_W-1:0]   rpm_cur;
  logic [47:0]         drag_sum;
  logic [48:0]         drive_ext, diff_pos, diff_neg;
  logic [63:0]         q_sat;
  logic [34:0]         vel_sum;
  logic                freeze;
  logic                in_acc;

  vds_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  vds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      torque_r    <= '0;
      brkf_r      <= '0;
      wgt_r       <= 32'h0001_0000;
      ratio_tab_r <= '0;
      dragc_r     <= '0;
      fric_r      <= '0;
      upshift_r   <= '0;
      downshift_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENGINE_TORQUE:    torque_r    <= cfg_data[WORD_W-1:0];
        REG_BRAKING_FORCE:    brkf_r      <= cfg_data[WORD_W-1:0];
        REG_VEHICLE_WEIGHT:   wgt_r       <= cfg_data[WORD_W-1:0];
        REG_GEAR_RATIO_TABLE: ratio_tab_r <= cfg_data;
        REG_DRAG_COEFF:       dragc_r     <= cfg_data[WORD_W-1:0];
        REG_FRICTION_FORCE:   fric_r      <= cfg_data[WORD_W-1:0];
        REG_UPSHIFT_RPM:      upshift_r   <= cfg_data[WORD_W-1:0];
        REG_DOWNSHIFT_RPM:    downshift_r <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: at most one multiply issued per step, product read in the following step
  always_comb begin
    rpm_cur   = rpm_sat(mul_p[43:8]);
    drag_sum  = {1'b0, dhi_r} + {16'b0, mul_p[47:16]};
    drive_ext = {13'b0, drive_r};
    diff_pos  = drive_ext - resist_r;
    diff_neg  = resist_r - drive_ext;
    q_sat     = (div_rsp.quotient > DV_MAX) ? DV_MAX : div_rsp.quotient;
    vel_sum   = {3'b0, vel_r} + q_sat[34:0];
    freeze    = (rpmw_r > RPM_ONE) && (gear_r == GEAR_TOP);

    state_nxt     = state_r;
    thr_nxt       = thr_r;
    brk_nxt       = brk_r;
    dt_nxt        = dt_r;
    app_nxt       = app_r;
    drive_nxt     = drive_r;
    resist_nxt    = resist_r;
    v2lo_nxt      = v2lo_r;
    dsat_nxt      = dsat_r;
    dhi_nxt       = dhi_r;
    drag_nxt      = drag_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    plo_nxt       = plo_r;
    vn_nxt        = vn_r;
    rpmw_nxt      = rpmw_r;
    vel_nxt       = vel_r;
    rpm_nxt       = rpm_r;
    gear_nxt      = gear_r;
    out_valid_nxt = out_valid_r;
    o_speed_nxt   = o_speed_r;
    o_rpm_nxt     = o_rpm_r;
    o_gear_nxt    = o_gear_r;
    o_app_nxt     = o_app_r;
    mul_a         = '0;
    mul_b         = '0;

    div_req.start    = 1'b0;
    div_req.dividend = {16'b0, plo_r} + {mul_p[31:0], 32'b0};
    div_req.divisor  = wgt_r;

    // result beat taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          thr_nxt   = in_ch.throttle;
          brk_nxt   = in_ch.brake;
          dt_nxt    = in_ch.delta_time;
          state_nxt = S_APP;
        end
      end
      // throttle times one minus brake
      S_APP: begin
        mul_a     = {16'b0, thr_r};
        mul_b     = {15'b0, PEDAL_ONE - {1'b0, brk_r}};
        state_nxt = S_DRV1;
      end
      S_DRV1: begin
        app_nxt   = mul_p[31:16];
        mul_a     = torque_r;
        mul_b     = {16'b0, mul_p[31:16]};
        state_nxt = S_DRV2;
      end
      // drive force through the current gear ratio
      S_DRV2: begin
        mul_a     = mul_p[47:16];
        mul_b     = {20'b0, gear_ratio(ratio_tab_r, gear_r)};
        state_nxt = S_BRK;
      end
      S_BRK: begin
        drive_nxt = mul_p[43:8];
        mul_a     = brkf_r;
        mul_b     = {16'b0, brk_r};
        state_nxt = S_VSQ;
      end
      // brake plus friction, then velocity squared
      S_VSQ: begin
        resist_nxt = {16'b0, {1'b0, mul_p[47:16]} + {1'b0, fric_r}};
        mul_a      = vel_r;
        mul_b      = vel_r;
        state_nxt  = S_DHI;
      end
      S_DHI: begin
        v2lo_nxt  = mul_p[31:16];
        mul_a     = dragc_r;
        mul_b     = mul_p[63:32];
        state_nxt = S_DLO;
      end
      S_DLO: begin
        dsat_nxt  = (mul_p[63:47] != '0);
        dhi_nxt   = mul_p[46:0];
        mul_a     = dragc_r;
        mul_b     = {16'b0, v2lo_r};
        state_nxt = S_DRAG;
      end
      // drag saturated at 2^47
      S_DRAG: begin
        drag_nxt  = (dsat_r || (drag_sum > DRAG_MAX)) ? DRAG_MAX : drag_sum;
        state_nxt = S_RES;
      end
      S_RES: begin
        resist_nxt = resist_r + {1'b0, drag_r};
        state_nxt  = S_NET;
      end
      // sign and magnitude of net force, floored at -2^47
      S_NET: begin
        if (drive_ext >= resist_r) begin
          neg_nxt = 1'b0;
          mag_nxt = diff_pos[47:0];
        end else begin
          neg_nxt = 1'b1;
          mag_nxt = (diff_neg > MAG_MAX) ? MAG_MAX[47:0] : diff_neg[47:0];
        end
        state_nxt = S_MLO;
      end
      // magnitude times time step in two halves
      S_MLO: begin
        mul_a     = mag_r[31:0];
        mul_b     = {16'b0, dt_r};
        state_nxt = S_MHI;
      end
      S_MHI: begin
        plo_nxt   = mul_p[47:0];
        mul_a     = {16'b0, mag_r[47:32]};
        mul_b     = {16'b0, dt_r};
        state_nxt = S_MSUM;
      end
      S_MSUM: begin
        div_req.start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_VEL;
        end
      end
      // new velocity clamped to the unsigned 32-bit range
      S_VEL: begin
        if (neg_r) begin
          vn_nxt = (q_sat[33:0] > {2'b0, vel_r}) ? '0 : (vel_r - q_sat[31:0]);
        end else begin
          vn_nxt = (vel_sum[34:32] != 3'd0) ? '1 : vel_sum[31:0];
        end
        state_nxt = S_R0;
      end
      S_R0: begin
        mul_a     = vn_r;
        mul_b     = {20'b0, gear_ratio(ratio_tab_r, gear_r)};
        state_nxt = S_R1;
      end
      // upshift test
      S_R1: begin
        rpmw_nxt = rpm_cur;
        if ((rpm_cur > upshift_r) && (gear_r != GEAR_TOP)) begin
          gear_nxt  = gear_r + GEAR_W'(1);
          state_nxt = S_R2;
        end else begin
          state_nxt = S_DN;
        end
      end
      S_R2: begin
        mul_a     = vn_r;
        mul_b     = {20'b0, gear_ratio(ratio_tab_r, gear_r)};
        state_nxt = S_R3;
      end
      S_R3: begin
        rpmw_nxt  = rpm_cur;
        state_nxt = S_DN;
      end
      // downshift test against the next lower gear
      S_DN: begin
        if (gear_r > GEAR_LOW) begin
          mul_a     = vn_r;
          mul_b     = {20'b0, gear_ratio(ratio_tab_r, gear_r - GEAR_W'(1))};
          state_nxt = S_DN2;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DN2: begin
        if (downshift_r > rpm_cur) begin
          gear_nxt = gear_r - GEAR_W'(1);
          rpmw_nxt = rpm_cur;
        end
        state_nxt = S_FIN;
      end
      // once the output is free, load the result beat and commit state (vel, rpm held if frozen)
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          if (!freeze) begin
            vel_nxt = vn_r;
            rpm_nxt = rpmw_r;
          end
          out_valid_nxt = 1'b1;
          o_speed_nxt   = freeze ? vel_r : vn_r;
          o_rpm_nxt     = freeze ? rpm_r : rpmw_r;
          o_gear_nxt    = gear_r;
          o_app_nxt     = app_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vel_r       <= '0;
      rpm_r       <= '0;
      gear_r      <= GEAR_LOW;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vel_r       <= vel_nxt;
      rpm_r       <= rpm_nxt;
      gear_r      <= gear_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // work and output payload
  always_ff @(posedge clk) begin
    thr_r     <= thr_nxt;
    brk_r     <= brk_nxt;
    dt_r      <= dt_nxt;
    app_r     <= app_nxt;
    drive_r   <= drive_nxt;
    resist_r  <= resist_nxt;
    v2lo_r    <= v2lo_nxt;
    dsat_r    <= dsat_nxt;
    dhi_r     <= dhi_nxt;
    drag_r    <= drag_nxt;
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
    plo_r     <= plo_nxt;
    vn_r      <= vn_nxt;
    rpmw_r    <= rpmw_nxt;
    o_speed_r <= o_speed_nxt;
    o_rpm_r   <= o_rpm_nxt;
    o_gear_r  <= o_gear_nxt;
    o_app_r   <= o_app_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.speed            = o_speed_r;
  assign out_ch.engine_rpm       = o_rpm_r;
  assign out_ch.current_gear     = o_gear_r;
  assign out_ch.applied_throttle = o_app_r;

endmodule

>>> rtl/vds_chk.sv
// port-level checker for the drivetrain step, bound to the top level
module vds_chk import vds_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [WORD_W-1:0]  speed,
  input logic [GEAR_W-1:0]  current_gear
);

  // one tick at a time: ready drops after an input beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a beat");

  // reported gear stays within one to five
  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((current_gear >= GEAR_LOW) && (current_gear <= GEAR_TOP)))
    else $error("result gear out of range");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result keeps its speed and gear
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(speed) && $stable(current_gear)))
    else $error("result payload changed while stalled");

endmodule

bind vehicle_drivetrain_step vds_chk u_vds_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .speed        (out_ch.speed),
  .current_gear (out_ch.current_gear)
);
